// ===== rtl/core/esa_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// esa_pkg: error statistics accumulator shared definitions
// Widths, function codes, sequencer states and the report record.
// ----------------------------------------------------------------------------
package esa_pkg;

	localparam int ERROR_BITS   = 24;
	localparam int COUNT_BITS   = 16;
	localparam int SUM_BITS     = 40;
	localparam int SQSUM_BITS   = 64;
	localparam int PROD_BITS    = 2 * ERROR_BITS;
	localparam int REM_BITS     = ERROR_BITS + 1;
	localparam int CS_BITS      = REM_BITS + 2;
	localparam int STEP_BITS    = 6;
	localparam int ROOT_STEPS   = ERROR_BITS;
	localparam int S_TDATA_BITS = 24;
	localparam int M_TDATA_BITS = 96;
	localparam int REPORT_BITS  = COUNT_BITS + 3 * ERROR_BITS + 3;

	typedef enum logic [1:0] {
		FUNC_ADD    = 2'd0,
		FUNC_REPORT = 2'd1,
		FUNC_CLEAR  = 2'd2
	} func_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SQ,
		ST_ACC,
		ST_DIVS,
		ST_LDQ,
		ST_DIVQ,
		ST_MSQ,
		ST_SUB,
		ST_SQRT,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic ready;
		logic div_step;
		logic sqrt_step;
		logic mul_en;
		logic res_valid;
	} ctl_t;

	typedef struct packed {
		logic                  sample_overflow;
		logic                  bound_fault;
		logic                  bound_ok;
		logic [ERROR_BITS-1:0] std_error;
		logic [ERROR_BITS-1:0] mean_error;
		logic [ERROR_BITS-1:0] max_error;
		logic [COUNT_BITS-1:0] count;
	} report_t;

endpackage
`default_nettype wire

// ===== rtl/core/esa_cmpsub.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// esa_cmpsub: shared compare and subtract unit
// One trial subtraction per cycle for the divider and square-root steps.
// ----------------------------------------------------------------------------
module esa_cmpsub (
	input  wire logic [esa_pkg::CS_BITS-1:0] a,
	input  wire logic [esa_pkg::CS_BITS-1:0] b,
	output logic                             ge,
	output logic [esa_pkg::CS_BITS-1:0]      diff
);
	import esa_pkg::*;

	logic [CS_BITS:0] wide;

	// borrow out of the extended subtraction says a < b
	assign wide = {1'b0, a} - {1'b0, b};
	assign ge   = ~wide[CS_BITS];
	assign diff = wide[CS_BITS-1:0];

endmodule
`default_nettype wire

// ===== rtl/core/esa_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// esa_core: accumulators and report sequencer
// Holds the running sums and steps the shared unit through the divisions
// and the square root of a report.
// ----------------------------------------------------------------------------
module esa_core (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                in_valid,
	output logic                                     in_ready,
	input  wire logic [1:0]                          in_func,
	input  wire logic [esa_pkg::ERROR_BITS-1:0]      in_error,
	input  wire logic [esa_pkg::ERROR_BITS-1:0]      bound,
	output logic                                     res_valid,
	input  wire logic                                res_ready,
	output esa_pkg::report_t                         res
);
	import esa_pkg::*;

	state_t                  state_q, state_d;
	ctl_t                    ctl;
	func_t                   func;
	logic                    accept;

	logic [COUNT_BITS-1:0]   count_q;
	logic [ERROR_BITS-1:0]   peak_q;
	logic [SUM_BITS-1:0]     sum_q;
	logic [SQSUM_BITS-1:0]   sqsum_q;
	logic                    fault_q;
	logic                    ovf_q;
	logic [STEP_BITS-1:0]    step_q;

	logic [ERROR_BITS-1:0]   e_q;
	logic [PROD_BITS-1:0]    prod_q;
	logic [SQSUM_BITS-1:0]   dq_q;
	logic [REM_BITS-1:0]     rem_q;
	logic [ERROR_BITS-1:0]   root_q;
	logic [ERROR_BITS-1:0]   mean_q;
	logic [PROD_BITS-1:0]    msq_q;

	logic [ERROR_BITS-1:0]   mul_op;
	logic [PROD_BITS-1:0]    prod_d;
	logic [CS_BITS-1:0]      cs_a, cs_b, cs_diff;
	logic                    cs_ge;
	logic                    step_last;
	logic                    var_pos;
	logic                    bound_ok;

	assign func   = func_t'(in_func);
	assign accept = ctl.ready & in_valid;

	assign step_last =
		(state_q == ST_DIVS && step_q == STEP_BITS'(SUM_BITS - 1)) ||
		(state_q == ST_DIVQ && step_q == STEP_BITS'(SQSUM_BITS - 1)) ||
		(state_q == ST_SQRT && step_q == STEP_BITS'(ROOT_STEPS - 1));

	assign var_pos  = msq_q > prod_q;
	assign bound_ok = peak_q <= bound;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					case (func)
						FUNC_ADD:    state_d = ST_SQ;
						FUNC_REPORT: state_d = (count_q == '0) ? ST_DONE : ST_DIVS;
						default:     state_d = ST_IDLE;
					endcase
				end
			end
			ST_SQ:   state_d = ST_ACC;
			ST_ACC:  state_d = ST_IDLE;
			ST_DIVS: state_d = step_last ? ST_LDQ : ST_DIVS;
			ST_LDQ:  state_d = ST_DIVQ;
			ST_DIVQ: state_d = step_last ? ST_MSQ : ST_DIVQ;
			ST_MSQ:  state_d = ST_SUB;
			ST_SUB:  state_d = var_pos ? ST_SQRT : ST_DONE;
			ST_SQRT: state_d = step_last ? ST_DONE : ST_SQRT;
			ST_DONE: state_d = res_ready ? ST_IDLE : ST_DONE;
			default: state_d = ST_IDLE;
		endcase
	end

	// control outputs
	always_comb begin
		ctl = '0;
		unique case (state_q)
			ST_IDLE: ctl.ready     = 1'b1;
			ST_SQ:   ctl.mul_en    = 1'b1;
			ST_MSQ:  ctl.mul_en    = 1'b1;
			ST_DIVS: ctl.div_step  = 1'b1;
			ST_DIVQ: ctl.div_step  = 1'b1;
			ST_SQRT: ctl.sqrt_step = 1'b1;
			ST_DONE: ctl.res_valid = 1'b1;
			default: ctl = '0;
		endcase
	end

	// shared multiplier: sample square, then mean square in a report
	assign mul_op = (state_q == ST_MSQ) ? mean_q : e_q;
	assign prod_d = mul_op * mul_op;

	// shared unit operands: restoring divide by count, or one root digit
	always_comb begin
		if (ctl.sqrt_step) begin
			cs_a = {rem_q, dq_q[SQSUM_BITS-1 -: 2]};
			cs_b = {1'b0, root_q, 2'b01};
		end else begin
			cs_a = {{(CS_BITS-COUNT_BITS-1){1'b0}}, rem_q[COUNT_BITS-1:0],
				dq_q[SQSUM_BITS-1]};
			cs_b = {{(CS_BITS-COUNT_BITS){1'b0}}, count_q};
		end
	end

	esa_cmpsub u_cmpsub (
		.a    (cs_a),
		.b    (cs_b),
		.ge   (cs_ge),
		.diff (cs_diff)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			peak_q  <= '0;
			sum_q   <= '0;
			sqsum_q <= '0;
			fault_q <= 1'b0;
			ovf_q   <= 1'b0;
			step_q  <= '0;
		end else begin
			state_q <= state_d;
			step_q  <= ((ctl.div_step || ctl.sqrt_step) && !step_last) ?
				step_q + STEP_BITS'(1) : '0;
			if (accept && func == FUNC_CLEAR) begin
				count_q <= '0;
				peak_q  <= '0;
				sum_q   <= '0;
				sqsum_q <= '0;
				fault_q <= 1'b0;
				ovf_q   <= 1'b0;
			end
			if (state_q == ST_ACC) begin
				if (count_q == '1) begin
					ovf_q <= 1'b1;
				end else begin
					count_q <= count_q + COUNT_BITS'(1);
					if (e_q > peak_q) begin
						peak_q <= e_q;
					end
					sum_q   <= sum_q + {{(SUM_BITS-ERROR_BITS){1'b0}}, e_q};
					sqsum_q <= sqsum_q + {{(SQSUM_BITS-PROD_BITS){1'b0}}, prod_q};
				end
			end
			if (ctl.res_valid && res_ready && !bound_ok) begin
				fault_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			e_q <= in_error;
		end
		if (accept && func == FUNC_REPORT) begin
			mean_q <= '0;
			root_q <= '0;
			dq_q   <= {sum_q, {(SQSUM_BITS-SUM_BITS){1'b0}}};
			rem_q  <= '0;
		end
		if (ctl.mul_en) begin
			prod_q <= prod_d;
		end
		if (ctl.div_step) begin
			rem_q <= {{(REM_BITS-COUNT_BITS){1'b0}},
				cs_ge ? cs_diff[COUNT_BITS-1:0] : cs_a[COUNT_BITS-1:0]};
			dq_q  <= {dq_q[SQSUM_BITS-2:0], cs_ge};
		end
		if (ctl.sqrt_step) begin
			rem_q  <= cs_ge ? cs_diff[REM_BITS-1:0] : cs_a[REM_BITS-1:0];
			root_q <= {root_q[ERROR_BITS-2:0], cs_ge};
			dq_q   <= {dq_q[SQSUM_BITS-3:0], 2'b00};
		end
		if (state_q == ST_LDQ) begin
			mean_q <= dq_q[ERROR_BITS-1:0];
			dq_q   <= sqsum_q;
			rem_q  <= '0;
		end
		if (state_q == ST_MSQ) begin
			msq_q <= dq_q[PROD_BITS-1:0];
		end
		if (state_q == ST_SUB) begin
			root_q <= '0;
			rem_q  <= '0;
			dq_q   <= {msq_q - prod_q, {(SQSUM_BITS-PROD_BITS){1'b0}}};
		end
	end

	assign in_ready  = ctl.ready;
	assign res_valid = ctl.res_valid;

	always_comb begin
		res                 = '0;
		res.count           = count_q;
		res.max_error       = peak_q;
		res.mean_error      = mean_q;
		res.std_error       = root_q;
		res.bound_ok        = bound_ok;
		res.bound_fault     = fault_q | ~bound_ok;
		res.sample_overflow = ovf_q;
	end

endmodule
`default_nettype wire

// ===== rtl/core/error_statistics_accumulator.sv =====
// Add transaction: square, then accumulate; the next transaction waits for both.
// Clear and unused codes: the next transaction is taken in the next cycle.
// Report: result in the output register after the bit-serial divisions (40 + 64
// steps) and the 24-step square root on the one compare/subtract unit; the root
// is skipped when the variance is zero, and all of them with no samples.
// arst_n low clears all accumulators, sticky flags and the bound register.
`default_nettype none
// ----------------------------------------------------------------------------
// error_statistics_accumulator: running error count, max, mean and std
// Stream front end, bound register and output register around the core.
// ----------------------------------------------------------------------------
module error_statistics_accumulator (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 s_tvalid,
	output logic                                      s_tready,
	input  wire logic [esa_pkg::S_TDATA_BITS-1:0]     s_tdata,  // [23:0] error
	input  wire logic [1:0]                           s_tuser,  // [1:0] func
	output logic                                      m_tvalid,
	input  wire logic                                 m_tready,
	// [15:0] count, [39:16] max_error, [63:40] mean_error, [87:64] std_error,
	// [88] bound_ok, [89] bound_fault, [90] sample_overflow, [95:91] zero
	output logic [esa_pkg::M_TDATA_BITS-1:0]          m_tdata,
	input  wire logic                                 cfg_wen,
	input  wire logic [esa_pkg::ERROR_BITS-1:0]       cfg_wdata
);
	import esa_pkg::*;

	logic [ERROR_BITS-1:0]   bound_q;
	logic                    m_tvalid_q;
	logic [M_TDATA_BITS-1:0] m_tdata_q;
	logic                    res_valid;
	logic                    res_ready;
	report_t                 res;

	// hold the bound; the user must write it only while the block is quiet, the block does not enforce it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bound_q <= '0;
		end else if (cfg_wen) begin
			bound_q <= cfg_wdata;
		end
	end

	// output register frees as soon as the sink takes the transaction
	assign res_ready = ~m_tvalid_q | m_tready;

	esa_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_func   (s_tuser),
		.in_error  (s_tdata[ERROR_BITS-1:0]),
		.bound     (bound_q),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (res_ready) begin
			m_tvalid_q <= res_valid;
		end
	end

	// pack the report, last struct field (count) lowest, zero pad to whole bytes
	always_ff @(posedge clk) begin
		if (res_ready && res_valid) begin
			m_tdata_q <= {{(M_TDATA_BITS-REPORT_BITS){1'b0}}, res};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

endmodule
`default_nettype wire

// ===== rtl/core/esa_checker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// esa_checker: port-level checks for the error statistics accumulator
// Watches the stream ports and the report contents over time.
// ----------------------------------------------------------------------------
module esa_checker (
	input wire logic                              clk,
	input wire logic                              arst_n,
	input wire logic                              s_tvalid,
	input wire logic                              s_tready,
	input wire logic [1:0]                        s_tuser,
	input wire logic                              m_tvalid,
	input wire logic                              m_tready,
	input wire logic [esa_pkg::M_TDATA_BITS-1:0]  m_tdata
);
	import esa_pkg::*;

	// a stalled report holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("report changed while stalled");

	// while a sample occupies the multiplier and accumulator, no transaction is taken
	a_add_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && s_tuser == FUNC_ADD |=> !s_tready)
		else $error("accepted a transaction during a sample update");

	// padding is zero and the mean never exceeds the maximum
	a_mean_le_max: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[95:91] == 5'd0 && m_tdata[63:40] <= m_tdata[39:16])
		else $error("mean above maximum or padding set");

	// no samples: mean and std read zero
	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[15:0] == 16'd0 |-> m_tdata[87:40] == 48'd0)
		else $error("empty report with nonzero mean or std");

	// a failed bound check always shows in the sticky fault
	a_fault: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tdata[88] |-> m_tdata[89])
		else $error("bound violation without sticky fault");

endmodule

bind error_statistics_accumulator esa_checker u_esa_checker (.*);
`default_nettype wire

// ===== test/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the error statistics accumulator
// Streams add, report, clear and unused-code transactions into the block,
// predicts every report from a local copy of the accumulators and the bound
// register, and compares each report field by field as it leaves the block.
// Covers empty counts, the sticky fault, bound edges, output back-pressure and
// long random traffic under several idling mixes.
// ----------------------------------------------------------------------------
module tb_top;
	import esa_pkg::*;

	localparam int      CLK_PERIOD      = 10;
	localparam int      RESET_CYCLES    = 7;
	localparam int      SETTLE_CYCLES   = 150;   // longest report latency plus margin
	localparam int      ITEMS_PER_PHASE = 380;
	localparam int      MAX_GAP         = 40;
	localparam int      HOLD_CYCLES     = 2000;
	localparam int      PRINT_LIMIT     = 40;
	localparam longint  TIMEOUT_NS      = 64'd40_000_000;
	localparam logic [1:0] FUNC_UNUSED  = 2'd3;
	localparam logic [ERROR_BITS-1:0] ERROR_MAX  = '1;

	logic                    clk       = 1'b0;
	logic                    arst_n    = 1'b0;
	logic                    s_tvalid  = 1'b0;
	logic                    s_tready;
	logic [S_TDATA_BITS-1:0] s_tdata   = '0;   // [23:0] error
	logic [1:0]              s_tuser   = '0;   // [1:0] func
	logic                    m_tvalid;
	logic                    m_tready  = 1'b0;
	// [15:0] count, [39:16] max_error, [63:40] mean_error, [87:64] std_error,
	// [88] bound_ok, [89] bound_fault, [90] sample_overflow, [95:91] zero
	logic [M_TDATA_BITS-1:0] m_tdata;
	logic                    cfg_wen   = 1'b0;
	logic [ERROR_BITS-1:0]   cfg_wdata = '0;

	// Predicted block state
	logic [COUNT_BITS-1:0] acc_count    = '0;
	logic [ERROR_BITS-1:0] acc_peak     = '0;
	logic [SUM_BITS-1:0]   acc_sum      = '0;
	logic [SQSUM_BITS-1:0] acc_sqsum    = '0;
	logic                  acc_fault    = 1'b0;
	logic                  acc_overflow = 1'b0;
	logic [ERROR_BITS-1:0] bound_reg    = '0;

	report_t pending_reports[$];
	report_t seen_report;
	report_t want_report;
	int      mismatch_count  = 0;
	int      src_idle_pct    = 0;
	int      sink_stall_pct  = 0;
	int      ready_hold_left = 0;

	error_statistics_accumulator dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_wen   (cfg_wen),
		.cfg_wdata (cfg_wdata)
	);

	initial begin
		forever #(CLK_PERIOD / 2) clk = ~clk;
	end

	initial begin
		#(TIMEOUT_NS);
		$display("Regression FAIL");
		$finish;
	end

	// Floor of the square root, one result bit at a time from the top
	function automatic logic [31:0] floor_sqrt(input logic [63:0] v);
		logic [63:0] root;
		logic [63:0] trial;
		root = '0;
		for (int b = 31; b >= 0; b--) begin
			trial = root | (64'd1 << b);
			if (trial * trial <= v)
				root = trial;
		end
		return root[31:0];
	endfunction

	// Advance the predicted state by one transaction; flag a report when one is due
	function automatic void update_statistics(input logic [1:0] code,
			input logic [ERROR_BITS-1:0] sample, output bit produced, output report_t rpt);
		logic [SQSUM_BITS-1:0] mean;
		logic [SQSUM_BITS-1:0] msq;
		logic [SQSUM_BITS-1:0] mean_sq;
		logic [31:0]           spread;
		bit                    bound_met;
		produced = 1'b0;
		rpt      = '0;
		case (code)
			FUNC_ADD: begin
				if (acc_count == '1) begin
					acc_overflow = 1'b1;
				end else begin
					acc_count++;
					if (sample > acc_peak)
						acc_peak = sample;
					acc_sum   = acc_sum + SUM_BITS'(sample);
					acc_sqsum = acc_sqsum + 64'(sample) * 64'(sample);
				end
			end
			FUNC_CLEAR: begin
				acc_count    = '0;
				acc_peak     = '0;
				acc_sum      = '0;
				acc_sqsum    = '0;
				acc_fault    = 1'b0;
				acc_overflow = 1'b0;
			end
			FUNC_REPORT: begin
				mean   = '0;
				spread = '0;
				if (acc_count != 0) begin
					mean    = 64'(acc_sum) / 64'(acc_count);
					msq     = acc_sqsum / 64'(acc_count);
					mean_sq = mean * mean;
					if (msq > mean_sq)
						spread = floor_sqrt(msq - mean_sq);
				end
				bound_met = (acc_peak <= bound_reg);
				if (!bound_met)
					acc_fault = 1'b1;
				rpt.count           = acc_count;
				rpt.max_error       = acc_peak;
				rpt.mean_error      = mean[ERROR_BITS-1:0];
				rpt.std_error       = spread[ERROR_BITS-1:0];
				rpt.bound_ok        = bound_met;
				rpt.bound_fault     = acc_fault;
				rpt.sample_overflow = acc_overflow;
				produced            = 1'b1;
			end
			default: ;   // unused code: no effect
		endcase
	endfunction

	task automatic report_mismatch(input string field, input longint unsigned got,
			input longint unsigned want);
		mismatch_count++;
		if (mismatch_count <= PRINT_LIMIT)
			$display("[%0t] mismatch on %s: got %0h, expected %0h", $time, field, got, want);
	endtask

	// Receiver: long hold-off takes priority over random stalls
	always @(posedge clk) begin
		if (ready_hold_left > 0) begin
			ready_hold_left--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= sink_stall_pct);
		end
	end

	// Compare each report transaction with the oldest prediction
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_reports.size() == 0) begin
				report_mismatch("unexpected report", 64'(m_tdata), 64'd0);
			end else begin
				want_report = pending_reports.pop_front();
				seen_report = report_t'(m_tdata[REPORT_BITS-1:0]);
				if (seen_report.count != want_report.count)
					report_mismatch("count", 64'(seen_report.count),
							64'(want_report.count));
				if (seen_report.max_error != want_report.max_error)
					report_mismatch("max_error", 64'(seen_report.max_error),
							64'(want_report.max_error));
				if (seen_report.mean_error != want_report.mean_error)
					report_mismatch("mean_error", 64'(seen_report.mean_error),
							64'(want_report.mean_error));
				if (seen_report.std_error != want_report.std_error)
					report_mismatch("std_error", 64'(seen_report.std_error),
							64'(want_report.std_error));
				if (seen_report.bound_ok != want_report.bound_ok)
					report_mismatch("bound_ok", 64'(seen_report.bound_ok),
							64'(want_report.bound_ok));
				if (seen_report.bound_fault != want_report.bound_fault)
					report_mismatch("bound_fault", 64'(seen_report.bound_fault),
							64'(want_report.bound_fault));
				if (seen_report.sample_overflow != want_report.sample_overflow)
					report_mismatch("sample_overflow", 64'(seen_report.sample_overflow),
							64'(want_report.sample_overflow));
				if (m_tdata[M_TDATA_BITS-1:REPORT_BITS] != '0)
					report_mismatch("padding", 64'(m_tdata[M_TDATA_BITS-1:REPORT_BITS]),
							64'd0);
			end
		end
	end

	task automatic set_idling(input int src_pct, input int sink_pct);
		src_idle_pct   = src_pct;
		sink_stall_pct = sink_pct;
	endtask

	// Offer one transaction, idling first at random; valid stays high on return
	task automatic send_item(input logic [1:0] code, input logic [ERROR_BITS-1:0] sample);
		int      gap;
		bit      produced;
		report_t rpt;
		gap = 0;
		while (gap < MAX_GAP && $urandom_range(99) < src_idle_pct)
			gap++;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			s_tdata  <= S_TDATA_BITS'($urandom);
			s_tuser  <= 2'($urandom);
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= sample;
		s_tuser  <= code;
		do @(posedge clk); while (!s_tready);
		update_statistics(code, sample, produced, rpt);
		if (produced)
			pending_reports.push_back(rpt);
	endtask

	// Drop valid, wait for every outstanding report, then let any add finish
	task automatic drain_block();
		s_tvalid <= 1'b0;
		while (pending_reports.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_bound(input logic [ERROR_BITS-1:0] value);
		drain_block();
		cfg_wen   <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_wen   <= 1'b0;
		bound_reg = value;
	endtask

	// Reports with no samples, and the unused code in between
	task automatic test_empty_statistics();
		send_item(FUNC_REPORT, ERROR_MAX);
		send_item(FUNC_UNUSED, ERROR_MAX);
		send_item(FUNC_REPORT, '0);
	endtask

	// Extreme and alternating samples against a zero bound; clear drops the fault
	task automatic test_field_extremes();
		send_item(FUNC_ADD, '0);
		send_item(FUNC_ADD, ERROR_MAX);
		send_item(FUNC_ADD, 24'hAAAAAA);
		send_item(FUNC_ADD, 24'h555555);
		send_item(FUNC_REPORT, '0);
		send_item(FUNC_REPORT, ERROR_MAX);
		send_item(FUNC_CLEAR, 24'h5A5A5A);
		send_item(FUNC_REPORT, '0);
	endtask

	// Equal samples give zero spread; bound checked at, above and below the peak
	task automatic test_bound_register();
		write_bound(ERROR_MAX);
		repeat (3) send_item(FUNC_ADD, 24'h012345);
		send_item(FUNC_REPORT, '0);
		write_bound(24'h012345);
		send_item(FUNC_REPORT, '0);
		write_bound(24'h012344);
		send_item(FUNC_REPORT, '0);
		send_item(FUNC_CLEAR, '0);
	endtask

	// Hold the output off for a long stretch while reports keep arriving
	task automatic test_output_backpressure();
		set_idling(0, 0);
		ready_hold_left = HOLD_CYCLES;
		for (int i = 0; i < 6; i++) begin
			repeat (3) send_item(FUNC_ADD, 24'($urandom));
			send_item(FUNC_REPORT, 24'($urandom));
		end
		drain_block();
	endtask

	// Mixed traffic over several idling mixes, with a new bound per phase
	task automatic test_random_traffic();
		int                    src_pct  [5] = '{0, 81, 0, 24, 0};
		int                    sink_pct [5] = '{0, 0, 81, 24, 0};
		logic [ERROR_BITS-1:0] run_value;
		logic [ERROR_BITS-1:0] sample;
		logic [1:0]            code;
		int                    pick;
		for (int p = 0; p < 5; p++) begin
			case (p)
				0:       write_bound('0);
				1:       write_bound(ERROR_MAX);
				default: write_bound(24'($urandom));
			endcase
			set_idling(src_pct[p], sink_pct[p]);
			run_value = ERROR_BITS'($urandom);
			for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
				pick = $urandom_range(99);
				if (pick < 80)
					code = FUNC_ADD;
				else if (pick < 92)
					code = FUNC_REPORT;
				else if (pick < 97)
					code = FUNC_CLEAR;
				else
					code = FUNC_UNUSED;
				// Mix wide, small, near-full and repeated samples
				case ($urandom_range(3))
					0:       sample = ERROR_BITS'($urandom);
					1:       sample = ERROR_BITS'($urandom_range(255));
					2:       sample = ERROR_MAX - ERROR_BITS'($urandom_range(255));
					default: sample = run_value;
				endcase
				send_item(code, sample);
			end
		end
	endtask

	initial begin
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		set_idling(0, 0);
		test_empty_statistics();
		test_field_extremes();
		test_bound_register();
		test_output_backpressure();
		test_random_traffic();
		drain_block();
		if (mismatch_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/core/esa_pkg.sv
rtl/core/esa_cmpsub.sv
rtl/core/esa_core.sv
rtl/core/error_statistics_accumulator.sv
rtl/core/esa_checker.sv
test/tb_top.sv
